[hdl/kcac_pkg.sv]
// Shared types, constants and helpers for the keypad code alarm controller.
package kcac_pkg;

   localparam int CODE_LENGTH = 5;                    // keys per code entry
   localparam int KEY_W       = 8;                    // one ASCII key code
   localparam int CODE_W      = 40;                   // code register width
   localparam int NUM_STORED  = CODE_LENGTH - 1;      // keys held before the final one
   localparam int POS_W       = $clog2(CODE_LENGTH);  // entry position width
   localparam int CSR_IDX_W   = 1;                    // two registers
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 8;

   localparam logic [KEY_W-1:0] KEY_STAR = 8'h2A;
   localparam logic [KEY_W-1:0] KEY_HASH = 8'h23;

   localparam logic [CODE_W-1:0] ARM_CODE_RESET    = 40'h313335372A;  // "1357*"
   localparam logic [CODE_W-1:0] DISARM_CODE_RESET = 40'h3133353723;  // "1357#"

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(CODE_LENGTH - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ARM_CODE    = 1'b0,
      CSR_DISARM_CODE = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_KEY  = 1'b0,
      OP_TRIP = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_DISARMED  = 2'd0,
      MODE_ARMED     = 2'd1,
      MODE_TRIGGERED = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      BEEP_NONE   = 2'd0,
      BEEP_SINGLE = 2'd1,
      BEEP_DOUBLE = 2'd2,
      BEEP_LONG   = 2'd3
   } beep_type;

   typedef logic [KEY_W-1:0] entry_keys_type [NUM_STORED];

   typedef struct packed {
      mode_type alarm_state;
      beep_type beep_request;
      logic     siren_on;
      logic     code_checked;
   } result_type;

   // Result fields from the lowest bit up, zero padded to a byte.
   function automatic logic [RSP_DATA_W-1:0] pack_result(input result_type r);
      pack_result = {2'b00, r.code_checked, r.siren_on, r.beep_request, r.alarm_state};
   endfunction

endpackage

[hdl/kcac_matcher.sv]
// Compares stored entry keys plus the final key against one code register.
module kcac_matcher (
   input  kcac_pkg::entry_keys_type       entry_keys,
   input  logic [kcac_pkg::KEY_W-1:0]     last_key,
   input  logic [kcac_pkg::CODE_W-1:0]    code,
   output logic                           match
);
   import kcac_pkg::*;

   logic [CODE_LENGTH-1:0] hits;

   // Key p pairs with code byte CODE_LENGTH-1-p; bytes past the register are zero.
   for (genvar p = 0; p < CODE_LENGTH; p++) begin : g_pos
      localparam int IDX = CODE_LENGTH - 1 - p;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] ref_byte;

      if (p == CODE_LENGTH - 1) begin : g_last
         assign key = last_key;
      end else begin : g_stored
         assign key = entry_keys[p];
      end

      if ((IDX + 1) * KEY_W <= CODE_W) begin : g_in
         assign ref_byte = code[IDX*KEY_W +: KEY_W];
      end else begin : g_out
         assign ref_byte = '0;
      end

      assign hits[p] = (key == ref_byte);
   end

   assign match = &hits;

endmodule

[hdl/kcac_core.sv]
// Entry buffer, position counter, alarm mode and per-item result logic.
module kcac_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  kcac_pkg::opcode_type         opcode,
   input  logic [kcac_pkg::KEY_W-1:0]   key_code,
   input  logic [kcac_pkg::CODE_W-1:0]  arm_code,
   input  logic [kcac_pkg::CODE_W-1:0]  disarm_code,
   output kcac_pkg::result_type         result
);
   import kcac_pkg::*;

   mode_type         mode_ff, mode_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   entry_keys_type   keys_ff;
   logic             arm_match, disarm_match;
   logic             key_step;

   kcac_matcher u_arm_match (
      .entry_keys (keys_ff),
      .last_key   (key_code),
      .code       (arm_code),
      .match      (arm_match)
   );

   kcac_matcher u_disarm_match (
      .entry_keys (keys_ff),
      .last_key   (key_code),
      .code       (disarm_code),
      .match      (disarm_match)
   );

   assign key_step = step && (opcode == OP_KEY);

   always_comb begin
      mode_in             = mode_ff;
      pos_in              = pos_ff;
      result.beep_request = BEEP_NONE;
      result.code_checked = 1'b0;
      if (step) begin
         unique case (opcode)
            OP_TRIP: begin
               if (mode_ff == MODE_ARMED) mode_in = MODE_TRIGGERED;
            end
            OP_KEY: begin
               if (pos_ff == LAST_POS) begin
                  result.code_checked = 1'b1;
                  pos_in              = '0;
                  // disarm wins when both codes match
                  priority if (disarm_match) begin
                     mode_in             = MODE_DISARMED;
                     result.beep_request = BEEP_DOUBLE;
                  end else if (arm_match) begin
                     mode_in             = MODE_ARMED;
                     result.beep_request = BEEP_SINGLE;
                  end else begin
                     result.beep_request = BEEP_LONG;
                  end
               end else if (key_code == KEY_STAR || key_code == KEY_HASH) begin
                  pos_in = '0;
               end else begin
                  pos_in = pos_ff + POS_W'(1);
               end
            end
            default: ;
         endcase
      end
      result.alarm_state = mode_in;
      result.siren_on    = (mode_in == MODE_TRIGGERED);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DISARMED;
         pos_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
      end
   end

   // Keys need no reset: an entry is compared only after every slot was written.
   always_ff @(posedge clock) begin
      if (key_step) begin
         for (int i = 0; i < NUM_STORED; i++) begin
            if (pos_ff == POS_W'(i)) keys_ff[i] <= key_code;
         end
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("entry position out of range");

   a_check_resets_pos: assert property (@(posedge clock) disable iff (reset)
      result.code_checked |=> pos_ff == '0)
      else $error("position not cleared after compare");

   a_trip_only_when_armed: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_TRIGGERED && mode_in == MODE_TRIGGERED |->
      mode_ff == MODE_ARMED && step && opcode == OP_TRIP)
      else $error("triggered without an armed gate trip");

endmodule

[hdl/keypad_code_alarm_controller.sv]
// Top level of the keypad code alarm controller: registers, stream ports, config.
//
//  channel | direction | ports                         | payload
//  --------+-----------+-------------------------------+-----------------------------------
//  req     | in        | req_tvalid/tready/tdata/tuser | tdata: key_code; tuser: opcode
//  rsp     | out       | rsp_tvalid/tready/tdata       | alarm_state, beep_request,
//          |           |                               | siren_on, code_checked
//  csr     | in        | csr_we/csr_index/csr_wdata    | 0 arm_code, 1 disarm_code
//
// One item per cycle sustained while rsp does not stall; a transfer taken on req
// reaches rsp through the input register, then the result register after the update logic.
// Key buffer, entry position and alarm mode change when an item moves into the
// result register, so each item sees everything earlier items left behind.
// A stalled rsp holds the result register; req still takes a transfer while the
// input register is empty. Synchronous reset clears mode, position and valids,
// and restores both code registers to their default codes.
module keypad_code_alarm_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [kcac_pkg::REQ_DATA_W-1:0]      req_tdata,   // [7:0] key_code
   input  logic                                 req_tuser,   // [0] opcode
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [kcac_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [1:0] alarm_state,
                                                             // [3:2] beep_request,
                                                             // [4] siren_on,
                                                             // [5] code_checked
   // register writes
   input  logic                                 csr_we,
   input  logic [kcac_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [kcac_pkg::CODE_W-1:0]          csr_wdata
);
   import kcac_pkg::*;

   logic [CODE_W-1:0] arm_code_ff, arm_code_in;
   logic [CODE_W-1:0] disarm_code_ff, disarm_code_in;

   logic              in_valid_ff, in_valid_in;
   opcode_type        in_opcode_ff;
   logic [KEY_W-1:0]  in_key_ff;

   logic              out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff;

   logic              advance;
   logic              step;
   logic              req_xfer;
   result_type        result;

   // ---- configuration registers ----
   always_comb begin
      arm_code_in    = arm_code_ff;
      disarm_code_in = disarm_code_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ARM_CODE:    arm_code_in    = csr_wdata;
            CSR_DISARM_CODE: disarm_code_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_code_ff    <= ARM_CODE_RESET;
         disarm_code_ff <= DISARM_CODE_RESET;
      end else begin
         arm_code_ff    <= arm_code_in;
         disarm_code_ff <= disarm_code_in;
      end
   end

   // ---- handshake ----
   // Result register frees up when empty or taken this cycle.
   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !step);
   assign out_valid_in = step || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_opcode_ff <= opcode_type'(req_tuser);
         in_key_ff    <= req_tdata[KEY_W-1:0];
      end
      if (step) out_data_ff <= pack_result(result);
   end

   // ---- update logic ----
   kcac_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .opcode      (in_opcode_ff),
      .key_code    (in_key_ff),
      .arm_code    (arm_code_ff),
      .disarm_code (disarm_code_ff),
      .result      (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // ---- checks ----
   a_beep_iff_checked: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5] == (rsp_tdata[3:2] != BEEP_NONE)))
      else $error("beep request without compare, or compare without beep");

   a_siren_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4] == (rsp_tdata[1:0] == MODE_TRIGGERED)))
      else $error("siren does not follow triggered state");

   a_arm_beep_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:2] == BEEP_SINGLE |-> rsp_tdata[1:0] == MODE_ARMED)
      else $error("arm beep without armed state");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !in_valid_ff)
      else $error("valid set right after reset");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the keypad code alarm controller stream block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import kcac_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;

   // One keypad event as presented on the request stream.
   typedef struct {
      opcode_type       op;
      logic [KEY_W-1:0] key;
   } keypad_event_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CODE_W-1:0]     csr_wdata   = '0;

   keypad_event_type pending_events[$];     // events still to be sent
   result_type       expected_results[$];   // one per accepted event, oldest first

   // Lock model state, mirrors the block's registers.
   logic [CODE_W-1:0] arm_code_m    = ARM_CODE_RESET;
   logic [CODE_W-1:0] disarm_code_m = DISARM_CODE_RESET;
   logic [KEY_W-1:0]  held_keys [NUM_STORED];
   int                entry_pos     = 0;
   mode_type          lock_mode     = MODE_DISARMED;

   int send_idle_pct = 0;   // chance per cycle that the sender holds off
   int recv_idle_pct = 0;   // chance per cycle that the receiver stalls
   int fail_count    = 0;
   int cycle_count   = 0;
   int gen_pos       = 0;   // entry position as seen by the event generator
   int gen_count     = 0;   // events queued so far

   keypad_code_alarm_controller u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] key_code
      .req_tuser  (req_tuser),    // [0] opcode
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [1:0] alarm_state, [3:2] beep_request,
                                  // [4] siren_on, [5] code_checked
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Lock model
   // ---------------------------------------------------------------------------------

   // Held keys plus the final key against a code; first key sits in the top byte.
   function automatic logic entry_equals(input logic [CODE_W-1:0] code,
                                         input logic [KEY_W-1:0] last_key);
      logic [KEY_W-1:0] k;
      for (int p = 0; p < CODE_LENGTH; p++) begin
         if (p == CODE_LENGTH - 1)
            k = last_key;
         else
            k = held_keys[p];
         if (k != code[(CODE_LENGTH-1-p)*KEY_W +: KEY_W])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // Advances the lock model by one event and returns the result it should give.
   function automatic result_type next_lock_result(input opcode_type op,
                                                   input logic [KEY_W-1:0] key);
      result_type r;
      logic       arm_hit;
      logic       disarm_hit;
      r.beep_request = BEEP_NONE;
      r.code_checked = 1'b0;
      if (op == OP_TRIP) begin
         // a trip only matters while armed
         if (lock_mode == MODE_ARMED)
            lock_mode = MODE_TRIGGERED;
      end else if (entry_pos == CODE_LENGTH - 1) begin
         // final key: compare, disarm wins when both codes match
         arm_hit    = entry_equals(arm_code_m, key);
         disarm_hit = entry_equals(disarm_code_m, key);
         r.code_checked = 1'b1;
         if (disarm_hit) begin
            lock_mode      = MODE_DISARMED;
            r.beep_request = BEEP_DOUBLE;
         end else if (arm_hit) begin
            lock_mode      = MODE_ARMED;
            r.beep_request = BEEP_SINGLE;
         end else begin
            r.beep_request = BEEP_LONG;   // mode untouched, also when triggered
         end
         entry_pos = 0;
      end else begin
         held_keys[entry_pos] = key;
         entry_pos++;
         if (key == KEY_STAR || key == KEY_HASH)
            entry_pos = 0;
      end
      r.alarm_state = lock_mode;
      r.siren_on    = (lock_mode == MODE_TRIGGERED);
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // Request driver: presents queued events, predicts on every accepted transfer
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      keypad_event_type ev;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(next_lock_result(opcode_type'(req_tuser), req_tdata));
         // bus slot is free when nothing is shown or the shown event just went
         if (!req_tvalid || req_tready) begin
            if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               ev = pending_events.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= ev.op;
               req_tdata  <= ev.key;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Result monitor: random backpressure, field-by-field check of each transfer
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      result_type want;
      result_type seen;
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.alarm_state  = mode_type'(rsp_tdata[1:0]);
         seen.beep_request = beep_type'(rsp_tdata[3:2]);
         seen.siren_on     = rsp_tdata[4];
         seen.code_checked = rsp_tdata[5];
         if (expected_results.size() == 0) begin
            $display("%0t: result with none expected: actual tdata=%h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (seen.alarm_state  !== want.alarm_state  ||
                seen.beep_request !== want.beep_request ||
                seen.siren_on     !== want.siren_on     ||
                seen.code_checked !== want.code_checked) begin
               $display("%0t: mismatch expected state=%0d beep=%0d siren=%0b checked=%0b",
                        $time, want.alarm_state, want.beep_request, want.siren_on,
                        want.code_checked);
               $display("%0t:          actual   state=%0d beep=%0d siren=%0b checked=%0b",
                        $time, seen.alarm_state, seen.beep_request, seen.siren_on,
                        seen.code_checked);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Event generation
   // ---------------------------------------------------------------------------------

   task automatic push_key(input logic [KEY_W-1:0] k);
      pending_events.push_back('{OP_KEY, k});
      gen_count++;
      if (gen_pos == CODE_LENGTH - 1 || k == KEY_STAR || k == KEY_HASH)
         gen_pos = 0;
      else
         gen_pos++;
   endtask

   // key_code is don't-care for a trip, so it carries noise
   task automatic push_trip();
      pending_events.push_back('{OP_TRIP, KEY_W'($urandom_range(0, 255))});
      gen_count++;
   endtask

   // Flushes a partial entry with filler keys, then types the full code.
   task automatic push_entry(input logic [CODE_W-1:0] code);
      while (gen_pos != 0)
         push_key(KEY_W'($urandom_range(0, 255)));
      for (int p = 0; p < CODE_LENGTH; p++)
         push_key(code[(CODE_LENGTH-1-p)*KEY_W +: KEY_W]);
   endtask

   // Random code that can actually be entered: no '*' or '#' before the final key.
   function automatic logic [CODE_W-1:0] enterable_code();
      logic [CODE_W-1:0] c;
      logic [KEY_W-1:0]  b;
      for (int i = 0; i < CODE_LENGTH; i++) begin
         b = KEY_W'($urandom_range(0, 255));
         while (i > 0 && (b == KEY_STAR || b == KEY_HASH))
            b = KEY_W'($urandom_range(0, 255));
         c[i*KEY_W +: KEY_W] = b;
      end
      return c;
   endfunction

   // Mostly well-formed code entries, with trips, near misses and stray keys mixed in.
   task automatic push_random_events(input int count);
      int               goal;
      int               pick;
      int               slot;
      logic [CODE_W-1:0] near;
      goal = gen_count + count;
      while (gen_count < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 32) begin
            push_entry(arm_code_m);
         end else if (pick < 58) begin
            push_entry(disarm_code_m);
         end else if (pick < 74) begin
            push_trip();
         end else if (pick < 86) begin
            // one flipped bit in one key of a valid code
            near = ($urandom_range(0, 1) != 0) ? arm_code_m : disarm_code_m;
            slot = $urandom_range(0, CODE_LENGTH - 1);
            near[slot*KEY_W + $urandom_range(0, KEY_W - 1)] ^= 1'b1;
            push_entry(near);
         end else if (pick < 92) begin
            push_key($urandom_range(0, 1) != 0 ? KEY_STAR : KEY_HASH);
         end else begin
            push_key(KEY_W'($urandom_range(0, 255)));
         end
      end
   endtask

   // Waits until every queued event went out and every result came back.
   task automatic wait_idle();
      while (pending_events.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called while the block is idle; model follows the write directly.
   task automatic write_code(input csr_index_type idx, input logic [CODE_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_ARM_CODE)
         arm_code_m = value;
      else
         disarm_code_m = value;
   endtask

   task automatic load_codes(input logic [CODE_W-1:0] arm, input logic [CODE_W-1:0] disarm);
      write_code(CSR_ARM_CODE, arm);
      write_code(CSR_DISARM_CODE, disarm);
   endtask

   // ---------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------
   initial begin
      logic [CODE_W-1:0] shared_code;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // sender idles lightly, receiver stalls a lot
      send_idle_pct = 16;
      recv_idle_pct = 56;

      // directed part on the reset codes
      push_trip();                        // trip while disarmed does nothing
      push_entry(ARM_CODE_RESET);         // star as the final key arms
      push_key(KEY_STAR);                 // star at the first position clears
      push_key(8'h31);
      push_key(KEY_HASH);                 // hash mid-entry clears
      push_trip();                        // armed -> triggered
      push_key(8'h00);                    // wrong code while triggered,
      push_key(8'hFF);                    // siren stays on
      push_key(8'h35);
      push_key(8'h37);
      push_key(8'h39);
      push_entry(DISARM_CODE_RESET);      // hash as the final key disarms
      wait_idle();                        // sender holds off until all results are back

      push_random_events(120);
      wait_idle();

      load_codes(enterable_code(), enterable_code());
      push_random_events(100);
      wait_idle();

      // roles swapped: sender gaps often, receiver rarely stalls
      send_idle_pct = 56;
      recv_idle_pct = 16;

      load_codes('0, '1);
      push_random_events(90);
      wait_idle();

      // identical codes: a matching entry always disarms
      shared_code = enterable_code();
      load_codes(shared_code, shared_code);
      push_entry(shared_code);
      push_trip();
      push_entry(shared_code);
      push_random_events(80);
      wait_idle();

      // back-to-back traffic
      send_idle_pct = 0;
      recv_idle_pct = 0;

      load_codes('1, '0);
      push_random_events(60);
      wait_idle();

      load_codes(enterable_code(), enterable_code());
      push_random_events(60);
      wait_idle();

      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
